### sv/rrt_tree_grow_defines.svh
// assertion macros for the tree grow block
`ifndef RRT_TREE_GROW_DEFINES_SVH
`define RRT_TREE_GROW_DEFINES_SVH
`define RTG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RTG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

### sv/rtg_pkg.sv
// package with types and constants of the tree grow block
package rtg_pkg;
  localparam int MaxNodes = 1024;
  localparam int CoordBits = 10;
  localparam int IdxBits = $clog2(MaxNodes);
  localparam int CntBits = IdxBits + 1;
  localparam int CfgBits = 10;
  localparam int SqBits = 2 * CoordBits + 1;
  localparam int NumObs = 3;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;

  localparam logic [1:0] FuncStart = 2'd0;
  localparam logic [1:0] FuncLoad  = 2'd1;
  localparam logic [1:0] FuncGrow  = 2'd2;

  localparam logic [1:0] RegStep  = 2'd0;
  localparam logic [1:0] RegGoal  = 2'd1;
  localparam logic [1:0] RegClear = 2'd2;
  localparam logic [1:0] RegLeft  = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] slot;
    coord_t     x;
    coord_t     y;
    coord_t     goal_x;
    coord_t     goal_y;
  } in_t;

  typedef struct packed {
    logic   added;
    idx_t   node_index;
    coord_t node_x;
    coord_t node_y;
    idx_t   parent_index;
    logic   done_res;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // capture input item
    logic do_start;
    logic do_load;
    logic scan_first; // first node of scan
    logic scan_rd;    // read node at scan index
    logic scan_cmp;   // compare read node
    logic sqrt_go;
    logic div_go;
    logic check;      // obstacle and wall check, append
    logic fin;        // build grow result
    logic idle_res;   // build result for start, load, unknown and skipped grow items
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       finished;
    logic       scan_last;
    logic       sqrt_busy;
    logic       div_busy;
  } sts_t;
endpackage

### sv/rtg_if.sv
// valid ready channel interface
interface rtg_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/rtg_ctrl.sv
// controller state machine of the tree grow block
module rtg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rtg_pkg::sts_t  sts_i,
  output rtg_pkg::cmd_t  cmd_o
);
  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StDec   = 8'b0000_0010,
    StRead  = 8'b0000_0100,
    StCmp   = 8'b0000_1000,
    StSqrt  = 8'b0001_0000,
    StDiv   = 8'b0010_0000,
    StCheck = 8'b0100_0000,
    StFin   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   first_q, first_d;

  assign in_ready_o  = (state_q == StIdle) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.latch = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        if (sts_i.func == rtg_pkg::FuncGrow && !sts_i.finished) begin
          cmd_o.scan_rd = 1'b1;
          first_d = 1'b1;
          state_d = StRead;
        end else begin
          cmd_o.do_start = (sts_i.func == rtg_pkg::FuncStart);
          cmd_o.do_load  = (sts_i.func == rtg_pkg::FuncLoad);
          cmd_o.idle_res = 1'b1;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      StRead: begin
        cmd_o.scan_cmp   = 1'b1;
        cmd_o.scan_first = first_q;
        first_d = 1'b0;
        state_d = StCmp;
      end
      StCmp: begin
        cmd_o.sqrt_go = 1'b1;
        state_d = StSqrt;
      end
      StSqrt: begin
        if (!sts_i.sqrt_busy) begin
          if (sts_i.scan_last) begin
            cmd_o.div_go = 1'b1;
            state_d = StDiv;
          end else begin
            cmd_o.scan_rd = 1'b1;
            state_d = StRead;
          end
        end
      end
      StDiv: begin
        if (!sts_i.div_busy) state_d = StCheck;
      end
      StCheck: begin
        cmd_o.check = 1'b1;
        state_d = StFin;
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        ov_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      first_q <= first_d;
    end
  end
endmodule

### sv/rtg_dp.sv
// datapath: node store, distance, square root, step divide and checks
module rtg_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rtg_pkg::cmd_t          cmd_i,
  output rtg_pkg::sts_t          sts_o,
  input  rtg_pkg::in_t           in_i,
  output rtg_pkg::out_t          out_o,
  input  logic [rtg_pkg::CfgBits-1:0] step_i,
  input  logic [rtg_pkg::CfgBits-1:0] goal_thr_i,
  input  logic [rtg_pkg::CfgBits-1:0] clear_i,
  input  logic [rtg_pkg::CfgBits-1:0] left_i
);
  localparam int CB = rtg_pkg::CoordBits;
  localparam int SB = rtg_pkg::SqBits;
  localparam int QB = CB + rtg_pkg::CfgBits;
  localparam int RB = CB + 1;

  rtg_pkg::coord_t mem_x [rtg_pkg::MaxNodes];
  rtg_pkg::coord_t mem_y [rtg_pkg::MaxNodes];
  rtg_pkg::idx_t   mem_p [rtg_pkg::MaxNodes];

  rtg_pkg::in_t    it_q;
  rtg_pkg::cnt_t   cnt_q;
  rtg_pkg::coord_t gx_q, gy_q, lnx_q, lny_q;
  rtg_pkg::coord_t obx_q [rtg_pkg::NumObs];
  rtg_pkg::coord_t oby_q [rtg_pkg::NumObs];
  logic [rtg_pkg::NumObs-1:0] obv_q;
  logic            fin_q;
  rtg_pkg::cnt_t   si_q;
  rtg_pkg::idx_t   cur_q, best_q;
  rtg_pkg::coord_t rx_q, ry_q, bx_q, by_q, ex_q, ey_q;
  logic [RB-1:0]   bestd_q;
  logic            added_q;
  rtg_pkg::out_t   out_q;

  // write port, shared by start and append
  logic            wr_en;
  rtg_pkg::idx_t   wr_a;
  rtg_pkg::coord_t wr_x, wr_y;
  rtg_pkg::idx_t   wr_p;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_a] <= wr_x;
      mem_y[wr_a] <= wr_y;
      mem_p[wr_a] <= wr_p;
    end
    if (cmd_i.scan_rd) begin
      rx_q <= mem_x[si_q[rtg_pkg::IdxBits-1:0]];
      ry_q <= mem_y[si_q[rtg_pkg::IdxBits-1:0]];
    end
  end

  function automatic logic [CB-1:0] absd(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // squared distance of read node to target, registered
  logic [SB-1:0] sq_q;
  logic [CB-1:0] ddx, ddy;
  assign ddx = absd(rx_q, it_q.x);
  assign ddy = absd(ry_q, it_q.y);

  // bit pair square root, one step a cycle
  localparam int SqSteps = (SB + 1) / 2;
  logic [2*SqSteps-1:0] srem_q, sval_q;
  logic [RB-1:0]        sroot_q;
  logic [$clog2(SqSteps+1)-1:0] scnt_q;
  logic                 sbusy_q;
  logic [2*SqSteps+1:0] trial;
  logic [2*SqSteps-1:0] rem_sh;
  assign rem_sh = {srem_q[2*SqSteps-3:0], sval_q[2*SqSteps-1 -: 2]};
  assign trial  = {2'b00, rem_sh} - {{(2*SqSteps-RB){1'b0}}, sroot_q, 2'b01};

  // restoring divider for mag*step / d
  logic [QB-1:0]   dnum_q [2];
  logic [QB-1:0]   dquo_q [2];
  logic [RB:0]     drem_q [2];
  logic [$clog2(QB+1)-1:0] dcnt_q;
  logic            dbusy_q, dpass_q;
  logic [CB-1:0]   magx, magy;
  logic [RB:0]     dsh [2];
  logic [RB:0]     dden;
  assign magx = absd(bx_q, it_q.x);
  assign magy = absd(by_q, it_q.y);
  assign dden = {1'b0, bestd_q};
  always_comb begin
    for (int k = 0; k < 2; k++) dsh[k] = {drem_q[k][RB-1:0], dnum_q[k][QB-1]};
  end

  // checks on the new point
  logic blocked;
  logic [SB-1:0] csq;
  always_comb begin
    blocked = (ex_q <= left_i);
    csq = SB'({11'd0, clear_i} * {11'd0, clear_i});
    for (int k = 0; k < rtg_pkg::NumObs; k++) begin
      if (obv_q[k] && (SB'({1'b0, absd(obx_q[k], ex_q)} * {1'b0, absd(obx_q[k], ex_q)})
          + SB'({1'b0, absd(oby_q[k], ey_q)} * {1'b0, absd(oby_q[k], ey_q)}) < csq))
        blocked = 1'b1;
    end
  end

  // finished when the last nearest node is within the goal threshold or the store is full
  function automatic logic fin_f(input logic [CB-1:0] ax, input logic [CB-1:0] ay,
                                 input logic [CB-1:0] px, input logic [CB-1:0] py,
                                 input logic [rtg_pkg::CfgBits-1:0] t,
                                 input rtg_pkg::cnt_t c);
    logic [SB-1:0] dd, tt;
    dd = SB'({1'b0, absd(ax, px)} * {1'b0, absd(ax, px)})
         + SB'({1'b0, absd(ay, py)} * {1'b0, absd(ay, py)});
    tt = SB'({11'd0, t} * {11'd0, t});
    return (dd <= tt) || (c >= rtg_pkg::cnt_t'(rtg_pkg::MaxNodes));
  endfunction

  // result of start, load and skipped items
  rtg_pkg::out_t res_idle;
  always_comb begin
    res_idle = '0;
    if (it_q.func == rtg_pkg::FuncStart) begin
      res_idle.added    = 1'b1;
      res_idle.node_x   = it_q.x;
      res_idle.node_y   = it_q.y;
      res_idle.done_res = fin_f(it_q.x, it_q.y, it_q.goal_x, it_q.goal_y, goal_thr_i,
                                rtg_pkg::cnt_t'(1));
    end else begin
      res_idle.done_res = fin_q;
    end
  end

  logic app;
  assign app = !blocked && (cnt_q < rtg_pkg::cnt_t'(rtg_pkg::MaxNodes));

  always_comb begin
    wr_en = 1'b0;
    wr_a  = '0;
    wr_x  = it_q.x;
    wr_y  = it_q.y;
    wr_p  = '0;
    if (cmd_i.do_start) wr_en = 1'b1;
    else if (cmd_i.check && app) begin
      wr_en = 1'b1;
      wr_a  = cnt_q[rtg_pkg::IdxBits-1:0];
      wr_x  = ex_q;
      wr_y  = ey_q;
      wr_p  = best_q;
    end
  end

  assign sts_o.func      = it_q.func;
  assign sts_o.finished  = fin_q;
  assign sts_o.scan_last = (si_q >= cnt_q);
  assign sts_o.sqrt_busy = sbusy_q;
  assign sts_o.div_busy  = dbusy_q;
  assign out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      gx_q    <= '0;
      gy_q    <= '0;
      lnx_q   <= '0;
      lny_q   <= '0;
      obv_q   <= '0;
      fin_q   <= 1'b1;
      sbusy_q <= 1'b0;
      dbusy_q <= 1'b0;
      for (int k = 0; k < rtg_pkg::NumObs; k++) begin
        obx_q[k] <= '0;
        oby_q[k] <= '0;
      end
    end else begin
      if (cmd_i.do_start) begin
        cnt_q <= rtg_pkg::cnt_t'(1);
        gx_q  <= it_q.goal_x;
        gy_q  <= it_q.goal_y;
        lnx_q <= it_q.x;
        lny_q <= it_q.y;
        fin_q <= fin_f(it_q.x, it_q.y, it_q.goal_x, it_q.goal_y, goal_thr_i,
                       rtg_pkg::cnt_t'(1));
      end
      if (cmd_i.do_load && it_q.slot < 2'(rtg_pkg::NumObs)) begin
        obx_q[it_q.slot] <= it_q.x;
        oby_q[it_q.slot] <= it_q.y;
        obv_q[it_q.slot] <= 1'b1;
      end
      if (cmd_i.check) begin
        if (app) cnt_q <= cnt_q + 1'b1;
        lnx_q <= bx_q;
        lny_q <= by_q;
        fin_q <= fin_f(bx_q, by_q, gx_q, gy_q, goal_thr_i,
                       app ? cnt_q + 1'b1 : cnt_q);
      end
      if (cmd_i.sqrt_go) sbusy_q <= 1'b1;
      else if (sbusy_q && scnt_q == '0) sbusy_q <= 1'b0;
      if (cmd_i.div_go) dbusy_q <= (bestd_q >= RB'(step_i)) && (step_i != '0);
      else if (dbusy_q && dcnt_q == '0) dbusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) it_q <= in_i;
    if (cmd_i.scan_rd) begin
      cur_q <= si_q[rtg_pkg::IdxBits-1:0];
      si_q  <= si_q + 1'b1;
    end
    if (cmd_i.do_start || cmd_i.latch) si_q <= '0;
    if (cmd_i.scan_cmp) begin
      sq_q <= SB'({1'b0, ddx} * {1'b0, ddx}) + SB'({1'b0, ddy} * {1'b0, ddy});
      if (cmd_i.scan_first) bestd_q <= '1;
    end
    if (cmd_i.sqrt_go) begin
      sval_q  <= (2*SqSteps)'(sq_q);
      srem_q  <= '0;
      sroot_q <= '0;
      scnt_q  <= ($clog2(SqSteps+1))'(SqSteps - 1);
    end else if (sbusy_q) begin
      sval_q <= {sval_q[2*SqSteps-3:0], 2'b00};
      if (!trial[2*SqSteps+1]) begin
        srem_q  <= trial[2*SqSteps-1:0];
        sroot_q <= {sroot_q[RB-2:0], 1'b1};
      end else begin
        srem_q  <= rem_sh;
        sroot_q <= {sroot_q[RB-2:0], 1'b0};
      end
      if (scnt_q != '0) scnt_q <= scnt_q - 1'b1;
      else if (({sroot_q[RB-2:0], !trial[2*SqSteps+1]} < bestd_q)
               || (bestd_q == '1 && cur_q == '0)) begin
        bestd_q <= {sroot_q[RB-2:0], !trial[2*SqSteps+1]};
        best_q  <= cur_q;
        bx_q    <= rx_q;
        by_q    <= ry_q;
      end
    end
    if (cmd_i.div_go) begin
      dnum_q[0] <= QB'(magx * step_i);
      dnum_q[1] <= QB'(magy * step_i);
      drem_q[0] <= '0;
      drem_q[1] <= '0;
      dcnt_q    <= ($clog2(QB+1))'(QB - 1);
      dpass_q   <= !((bestd_q >= RB'(step_i)) && (step_i != '0));
      if (step_i == '0 && bestd_q != '0) begin
        ex_q <= bx_q;
        ey_q <= by_q;
      end else begin
        ex_q <= it_q.x;
        ey_q <= it_q.y;
      end
    end else if (dbusy_q) begin
      for (int k = 0; k < 2; k++) begin
        dnum_q[k] <= {dnum_q[k][QB-2:0], 1'b0};
        if (dsh[k] >= dden) begin
          drem_q[k] <= dsh[k] - dden;
          dquo_q[k] <= {dquo_q[k][QB-2:0], 1'b1};
        end else begin
          drem_q[k] <= dsh[k];
          dquo_q[k] <= {dquo_q[k][QB-2:0], 1'b0};
        end
      end
      if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
    end else if (!dpass_q && !cmd_i.check && !cmd_i.fin) begin
      ex_q <= (it_q.x >= bx_q) ? bx_q + CB'(dquo_q[0]) : bx_q - CB'(dquo_q[0]);
      ey_q <= (it_q.y >= by_q) ? by_q + CB'(dquo_q[1]) : by_q - CB'(dquo_q[1]);
      dpass_q <= 1'b1;
    end
    if (cmd_i.check) added_q <= app;
    if (cmd_i.idle_res) out_q <= res_idle;
    if (cmd_i.fin) begin
      out_q.added        <= added_q;
      out_q.node_index   <= added_q ? cnt_q[rtg_pkg::IdxBits-1:0] - 1'b1 : '0;
      out_q.node_x       <= added_q ? ex_q : '0;
      out_q.node_y       <= added_q ? ey_q : '0;
      out_q.parent_index <= best_q;
      out_q.done_res     <= fin_q;
    end
  end
endmodule

### sv/rtg_regs.sv
// apb register file of the tree grow block
module rtg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [rtg_pkg::CfgBits-1:0] step_o,
  output logic [rtg_pkg::CfgBits-1:0] goal_o,
  output logic [rtg_pkg::CfgBits-1:0] clear_o,
  output logic [rtg_pkg::CfgBits-1:0] left_o
);
  logic [rtg_pkg::CfgBits-1:0] step_q, goal_q, clear_q, left_q;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 10'd20;
      goal_q  <= 10'd10;
      clear_q <= 10'd40;
      left_q  <= 10'd0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        rtg_pkg::RegStep:  step_q  <= pwdata[9:0];
        rtg_pkg::RegGoal:  goal_q  <= pwdata[9:0];
        rtg_pkg::RegClear: clear_q <= pwdata[9:0];
        rtg_pkg::RegLeft:  left_q  <= pwdata[9:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      rtg_pkg::RegStep:  prdata = {22'd0, step_q};
      rtg_pkg::RegGoal:  prdata = {22'd0, goal_q};
      rtg_pkg::RegClear: prdata = {22'd0, clear_q};
      rtg_pkg::RegLeft:  prdata = {22'd0, left_q};
      default:           prdata = '0;
    endcase
  end
  assign step_o  = step_q;
  assign goal_o  = goal_q;
  assign clear_o = clear_q;
  assign left_o  = left_q;
endmodule

### sv/rrt_tree_grow.sv
// top level of the tree grow block
// usage:
//   in_ch carries start, obstacle load and grow items; out_ch returns one beat per item
//   apb port writes step, goal threshold, clearance and wall limit (byte address 4*i)
// flow:
//   start, load and skipped grow items are registered on input, and the decode state
//   then builds their result beat into the output register
//   a grow item scans each stored node in turn through a squared distance and a
//   bit pair square root of 11 steps, then a 20 step divide for the step
//   (no divide runs when the target is within one step or the step is zero)
//   one item is in work at a time; the next is taken as the result beat leaves
// reset:
//   tree empty, finished set, no obstacles loaded, registers at their reset values
//   node store needs no clearing, only entries below the count are read
// stall:
//   a result beat holds in the output register until out_ch.ready; input waits
module rrt_tree_grow (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtg_if.sink         in_ch,
  rtg_if.source       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  `include "rrt_tree_grow_defines.svh"

  rtg_pkg::cmd_t cmd;
  rtg_pkg::sts_t sts;
  logic [rtg_pkg::CfgBits-1:0] step, goal, clear, left;

  rtg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .step_o(step), .goal_o(goal), .clear_o(clear), .left_o(left)
  );

  rtg_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  rtg_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_i(in_ch.data), .out_o(out_ch.data),
    .step_i(step), .goal_thr_i(goal), .clear_i(clear), .left_i(left)
  );

  `RTG_ASSERT(a_take_once, in_ch.valid && in_ch.ready |=> !in_ch.ready, "double take")
  `RTG_ASSERT(a_out_holds, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result beat lost")
  `RTG_ASSERT_RST(a_one_cmd, $onehot0({cmd.latch, cmd.check, cmd.fin, cmd.idle_res}), "cmd clash")
endmodule

### tb/tb.sv
// self-checking testbench of the tree grow block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 100000;

  typedef struct {
    rtg_pkg::in_t  item;
    bit            typed;
    rtg_pkg::out_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rtg_if #(.T(rtg_pkg::in_t))  in_ch ();
  rtg_if #(.T(rtg_pkg::out_t)) out_ch ();

  rrt_tree_grow dut (
    .clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of configuration and state
  int unsigned step_cfg, thr_cfg, clr_cfg, wall_cfg;
  int unsigned node_xs[rtg_pkg::MaxNodes], node_ys[rtg_pkg::MaxNodes];
  int unsigned node_cnt, goal_xp, goal_yp, near_x, near_y;
  int unsigned obs_x[rtg_pkg::NumObs], obs_y[rtg_pkg::NumObs];
  bit          obs_on[rtg_pkg::NumObs];
  bit          tree_done;

  rtg_pkg::out_t exp_q[$];
  int   errors = 0;
  int   idle_pct = 0, stall_pct = 0;
  int   quiet = 0;

  function automatic longint unsigned sq_dist(int unsigned ax, ay, bx, by);
    longint unsigned dx, dy;
    dx = ax > bx ? ax - bx : bx - ax;
    dy = ay > by ? ay - by : by - ay;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int unsigned step_toward(int unsigned from, to, longint unsigned d);
    longint unsigned mag, q;
    mag = to >= from ? to - from : from - to;
    q = mag * step_cfg / d;
    return to >= from ? 32'(from + q) : 32'(from - q);
  endfunction

  function automatic void update_done();
    longint unsigned t;
    t = thr_cfg;
    tree_done = (sq_dist(near_x, near_y, goal_xp, goal_yp) <= t * t)
                || node_cnt >= rtg_pkg::MaxNodes;
  endfunction

  function automatic rtg_pkg::out_t tree_predict(rtg_pkg::in_t it);
    rtg_pkg::out_t r;
    int unsigned best, ex, ey;
    longint unsigned bestd, cd, c;
    bit blocked;
    r = '0;
    if (it.func == rtg_pkg::FuncStart) begin
      node_xs[0] = it.x;
      node_ys[0] = it.y;
      node_cnt = 1;
      goal_xp = it.goal_x;
      goal_yp = it.goal_y;
      near_x = it.x;
      near_y = it.y;
      update_done();
      r.added = 1'b1;
      r.node_x = it.x;
      r.node_y = it.y;
    end else if (it.func == rtg_pkg::FuncLoad) begin
      if (it.slot < rtg_pkg::NumObs) begin
        obs_x[it.slot] = it.x;
        obs_y[it.slot] = it.y;
        obs_on[it.slot] = 1'b1;
      end
    end else if (it.func == rtg_pkg::FuncGrow && !tree_done) begin
      best = 0;
      bestd = '1;
      blocked = 1'b0;
      for (int i = 0; i < node_cnt; i++) begin
        cd = int_sqrt(sq_dist(node_xs[i], node_ys[i], it.x, it.y));
        if (cd < bestd) begin
          bestd = cd;
          best = i;
        end
      end
      if (bestd < step_cfg) begin
        ex = it.x;
        ey = it.y;
      end else if (bestd == 0) begin
        ex = node_xs[best];
        ey = node_ys[best];
      end else begin
        ex = step_toward(node_xs[best], it.x, bestd);
        ey = step_toward(node_ys[best], it.y, bestd);
      end
      c = clr_cfg;
      for (int i = 0; i < rtg_pkg::NumObs; i++)
        if (obs_on[i] && sq_dist(obs_x[i], obs_y[i], ex, ey) < c * c) blocked = 1'b1;
      if (ex <= wall_cfg) blocked = 1'b1;
      r.parent_index = rtg_pkg::idx_t'(best);
      if (!blocked && node_cnt < rtg_pkg::MaxNodes) begin
        node_xs[node_cnt] = ex;
        node_ys[node_cnt] = ey;
        r.added = 1'b1;
        r.node_index = rtg_pkg::idx_t'(node_cnt);
        r.node_x = rtg_pkg::coord_t'(ex);
        r.node_y = rtg_pkg::coord_t'(ey);
        node_cnt++;
      end
      near_x = node_xs[best];
      near_y = node_ys[best];
      update_done();
    end
    r.done_res = tree_done;
    return r;
  endfunction

  task automatic reg_write(logic [1:0] idx, int unsigned v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rtg_pkg::RegStep:  step_cfg = v & 10'h3ff;
      rtg_pkg::RegGoal:  thr_cfg = v & 10'h3ff;
      rtg_pkg::RegClear: clr_cfg = v & 10'h3ff;
      rtg_pkg::RegLeft:  wall_cfg = v & 10'h3ff;
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned s, g, c, l);
    reg_write(rtg_pkg::RegStep, s);
    reg_write(rtg_pkg::RegGoal, g);
    reg_write(rtg_pkg::RegClear, c);
    reg_write(rtg_pkg::RegLeft, l);
  endtask

  task automatic drain();
    while (exp_q.size() != 0) @(posedge clk_i);
  endtask

  // one beat on the input channel, with a random gap ahead of it
  task automatic send_beat(rtg_pkg::in_t it, bit typed, rtg_pkg::out_t res);
    int gap;
    rtg_pkg::out_t p;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    p = tree_predict(it);
    exp_q.insert(exp_q.size(), typed ? res : p);
  endtask

  function automatic rtg_pkg::in_t mk_in(logic [1:0] f, int unsigned s, x, y, gx, gy);
    rtg_pkg::in_t it;
    it.func = f;
    it.slot = 2'(s);
    it.x = rtg_pkg::coord_t'(x);
    it.y = rtg_pkg::coord_t'(y);
    it.goal_x = rtg_pkg::coord_t'(gx);
    it.goal_y = rtg_pkg::coord_t'(gy);
    return it;
  endfunction

  function automatic rtg_pkg::out_t mk_out(int unsigned a, i, x, y, p, d);
    rtg_pkg::out_t r;
    r.added = 1'(a);
    r.node_index = rtg_pkg::idx_t'(i);
    r.node_x = rtg_pkg::coord_t'(x);
    r.node_y = rtg_pkg::coord_t'(y);
    r.parent_index = rtg_pkg::idx_t'(p);
    r.done_res = 1'(d);
    return r;
  endfunction

  function automatic int unsigned near_coord(int unsigned c, int unsigned span);
    int v;
    v = int'(c) + $urandom_range(2 * span) - int'(span);
    return v < 0 ? 0 : (v > 1023 ? 1023 : v);
  endfunction

  task automatic random_phase(int n);
    int unsigned cap, rx, ry, k;
    rtg_pkg::in_t it;
    cap = $urandom_range(4, 40);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      rx = $urandom_range(1023);
      ry = $urandom_range(1023);
      if (node_cnt == 0 || node_cnt >= cap || (tree_done && k < 85)) begin
        cap = $urandom_range(4, 40);
        if ($urandom_range(99) < 30)
          it = mk_in(rtg_pkg::FuncStart, $urandom_range(3), rx, ry,
                     near_coord(rx, 60), near_coord(ry, 60));
        else
          it = mk_in(rtg_pkg::FuncStart, $urandom_range(3), rx, ry,
                     $urandom_range(1023), $urandom_range(1023));
      end else if (k < 8) begin
        it = mk_in(rtg_pkg::FuncLoad, $urandom_range(3), rx, ry,
                   $urandom_range(1023), $urandom_range(1023));
      end else if (k < 11) begin
        it = mk_in(2'd3, $urandom_range(3), rx, ry, $urandom_range(1023), $urandom_range(1023));
      end else if (k < 25) begin
        it = mk_in(rtg_pkg::FuncGrow, $urandom_range(3), near_coord(goal_xp, 30),
                   near_coord(goal_yp, 30), $urandom_range(1023), $urandom_range(1023));
      end else begin
        it = mk_in(rtg_pkg::FuncGrow, $urandom_range(3), rx, ry,
                   $urandom_range(1023), $urandom_range(1023));
      end
      send_beat(it, 1'b0, '0);
      if (i == n / 2) begin
        in_ch.valid <= 1'b0;
        drain();
      end
    end
    in_ch.valid <= 1'b0;
    drain();
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin : rx
    rtg_pkg::out_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (exp_q.size() == 0) begin
        $error("unexpected result beat %p", out_ch.data);
        errors++;
      end else begin
        e = exp_q.pop_front();
        if (out_ch.data.added !== e.added) begin
          $error("added exp %0d got %0d", e.added, out_ch.data.added);
          errors++;
        end
        if (out_ch.data.node_index !== e.node_index) begin
          $error("node_index exp %0d got %0d", e.node_index, out_ch.data.node_index);
          errors++;
        end
        if (out_ch.data.node_x !== e.node_x) begin
          $error("node_x exp %0d got %0d", e.node_x, out_ch.data.node_x);
          errors++;
        end
        if (out_ch.data.node_y !== e.node_y) begin
          $error("node_y exp %0d got %0d", e.node_y, out_ch.data.node_y);
          errors++;
        end
        if (out_ch.data.parent_index !== e.parent_index) begin
          $error("parent_index exp %0d got %0d", e.parent_index, out_ch.data.parent_index);
          errors++;
        end
        if (out_ch.data.done_res !== e.done_res) begin
          $error("done_res exp %0d got %0d", e.done_res, out_ch.data.done_res);
          errors++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on cycles with no beat on either channel and no apb access
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("[rrt_tree_grow] ERROR");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    rtg_pkg::out_t none;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    none = '0;
    step_cfg = 20;
    thr_cfg = 10;
    clr_cfg = 40;
    wall_cfg = 0;
    node_cnt = 0;
    goal_xp = 0;
    goal_yp = 0;
    near_x = 0;
    near_y = 0;
    tree_done = 1'b1;
    foreach (obs_on[i]) begin
      obs_on[i] = 1'b0;
      obs_x[i] = 0;
      obs_y[i] = 0;
    end

    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 5, 5, 0, 0), 1'b1,
                               mk_out(0, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncLoad, 3, 1023, 1023, 1023, 1023), 1'b1,
                               mk_out(0, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_in(2'd3, 2, 1023, 0, 0, 1023), 1'b1,
                               mk_out(0, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncStart, 0, 0, 0, 0, 0), 1'b1,
                               mk_out(1, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 1, 1023, 1023, 0, 0), 1'b1,
                               mk_out(0, 0, 0, 0, 0, 1)});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncStart, 3, 1023, 1023, 0, 0), 1'b1,
                               mk_out(1, 0, 1023, 1023, 0, 0)});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 0, 0, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 1023, 1023, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 1023, 0, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncLoad, 0, 1000, 1000, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncLoad, 1, 0, 1023, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncLoad, 2, 512, 512, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 1000, 1000, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncStart, 0, 0, 512, 1023, 512), 1'b1,
                               mk_out(1, 0, 0, 512, 0, 0)});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 1023, 512, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 0, 0, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 5, 512, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncStart, 0, 100, 100, 105, 100), 1'b1,
                               mk_out(1, 0, 100, 100, 0, 1)});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncStart, 0, 200, 800, 218, 800), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 290, 800, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 218, 800, 0, 0), 1'b0, none});
    rows.insert(rows.size(), '{mk_in(rtg_pkg::FuncGrow, 0, 300, 300, 0, 0), 1'b0, none});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_beat(rows[i].item, rows[i].typed, rows[i].res);
    in_ch.valid <= 1'b0;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_regs(1, 0, 0, 0);
        1: set_regs(1023, 1023, 1023, 1023);
        2: set_regs(0, 5, 20, 100);
        3: set_regs(20, 10, 40, 0);
        default: set_regs($urandom_range(1, 200), $urandom_range(40),
                          $urandom_range(80), $urandom_range(300));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      random_phase(104);
    end

    drain();
    repeat (30) @(posedge clk_i);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("[rrt_tree_grow] OK");
    end else begin
      $display("[rrt_tree_grow] ERROR");
    end
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/rtg_pkg.sv
sv/rtg_if.sv
sv/rtg_ctrl.sv
sv/rtg_dp.sv
sv/rtg_regs.sv
sv/rrt_tree_grow.sv
tb/tb.sv
